>>> hdl/sws_pkg.sv
// Package with the word types, codes and segment table of the stopwatch scanner.
`default_nettype none

package sws_pkg;

    // Input word: what kind of slot and the stopwatch mode.
    typedef struct packed {
        logic       kind;
        logic [1:0] mode;
    } item_t;

    // Result word: optional display frame plus the digits after the item.
    typedef struct packed {
        logic        frame_valid;
        logic [15:0] frame;
        logic [3:0]  tenths;
        logic [3:0]  sec_units;
        logic [2:0]  sec_tens;
        logic [3:0]  minutes;
    } result_t;

    // The four stopwatch digits as they travel between modules.
    typedef struct packed {
        logic [3:0] tenths;
        logic [3:0] sec_units;
        logic [2:0] sec_tens;
        logic [3:0] minutes;
    } digits_t;

    // Item kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REFRESH = 1'b1;

    // Mode codes; any other code behaves as hold.
    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_HOLD  = 2'd2;

    // Display numbers held in the selection register.
    localparam logic [2:0] DISP_TENTHS    = 3'd1;
    localparam logic [2:0] DISP_SEC_UNITS = 3'd2;
    localparam logic [2:0] DISP_SEC_TENS  = 3'd3;
    localparam logic [2:0] DISP_MINUTES   = 3'd4;

    // Frame constants.
    localparam logic [15:0] FRAME_DARK = 16'h00FF;
    localparam logic [7:0]  SEG_BAD    = 8'hFE;
    localparam logic [7:0]  POINT_ON   = 8'hFE;

    // Reset value of the ticks-per-tenth register.
    localparam logic [15:0] PERIOD_RESET = 16'd100;

    // Active-low segment byte for a digit: bit 0 is the point, bits 7..1 are a..g.
    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'h03;
            4'd1:    code = 8'h9F;
            4'd2:    code = 8'h25;
            4'd3:    code = 8'h0D;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h49;
            4'd6:    code = 8'h41;
            4'd7:    code = 8'h1F;
            4'd8:    code = 8'h01;
            4'd9:    code = 8'h09;
            default: code = SEG_BAD;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

>>> hdl/sws_time.sv
// Prescaler, period register and BCD digit counters of the stopwatch.
`default_nettype none

module sws_time (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_valid,
    input  wire logic [15:0]     cfg_data,
    input  wire logic            accept,
    input  wire sws_pkg::item_t  item,
    output sws_pkg::digits_t     digits_next
);
    import sws_pkg::*;

    logic [15:0] period_reg;
    logic [15:0] prescaler_reg;
    logic [15:0] prescaler_next;
    digits_t     digits_reg;
    digits_t     cleared;
    digits_t     stepped;
    logic [16:0] pre_inc;
    logic        run_tick;
    logic [4:0]  tenths_inc;
    logic [4:0]  units_inc;
    logic [3:0]  tens_inc;
    logic [4:0]  minutes_inc;

    // A clear applies to every item, before the tick is counted.
    always_comb
    begin
        cleared = digits_reg;
        if (item.mode == MODE_CLEAR)
        begin
            cleared = '0;
        end
    end

    // Prescaler: a zero period completes on every run tick, like a period of one.
    assign run_tick = (item.kind == KIND_TICK) && (item.mode == MODE_RUN);
    assign pre_inc  = {1'b0, prescaler_reg} + 17'd1;

    // BCD carry chain for one added tenth.
    assign tenths_inc  = {1'b0, cleared.tenths} + 5'd1;
    assign units_inc   = {1'b0, cleared.sec_units} + 5'd1;
    assign tens_inc    = {1'b0, cleared.sec_tens} + 4'd1;
    assign minutes_inc = {1'b0, cleared.minutes} + 5'd1;

    always_comb
    begin
        stepped        = cleared;
        prescaler_next = prescaler_reg;
        if (run_tick)
        begin
            if (pre_inc >= {1'b0, period_reg})
            begin
                prescaler_next = '0;
                if (tenths_inc < 5'd10)
                begin
                    stepped.tenths = tenths_inc[3:0];
                end
                else
                begin
                    stepped.tenths = '0;
                    if (units_inc < 5'd10)
                    begin
                        stepped.sec_units = units_inc[3:0];
                    end
                    else
                    begin
                        stepped.sec_units = '0;
                        if (tens_inc < 4'd6)
                        begin
                            stepped.sec_tens = tens_inc[2:0];
                        end
                        else
                        begin
                            stepped.sec_tens = '0;
                            if (minutes_inc >= 5'd10)
                            begin
                                stepped.minutes = '0;
                            end
                            else
                            begin
                                stepped.minutes = minutes_inc[3:0];
                            end
                        end
                    end
                end
            end
            else
            begin
                prescaler_next = pre_inc[15:0];
            end
        end
    end

    assign digits_next = stepped;

    // Digits and prescaler change only on accept, the period on cfg_valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= PERIOD_RESET;
            prescaler_reg <= '0;
            digits_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                period_reg <= cfg_data;
            end
            if (accept)
            begin
                prescaler_reg <= prescaler_next;
                digits_reg    <= stepped;
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/stopwatch_seven_segment_scanner.sv
// A result word is registered and appears in the cycle after its item word is accepted.
// Throughput: one item word per cycle; the result register frees up in the same
// cycle its word is taken, so the only stall is a held result.
// Reset (asynchronous, active low) zeroes the digits and the prescaler, selects
// display 1, sets the period to 100 ticks and empties the result register.
`default_nettype none

module stopwatch_seven_segment_scanner (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [15:0]      cfg_data,
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire sws_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output sws_pkg::result_t      result
);
    import sws_pkg::*;

    logic       accept;
    digits_t    digits_next;
    logic [2:0] select_reg;
    logic [2:0] select_next;
    logic [2:0] limit;
    logic       upper_zero;
    logic [15:0] frame;
    result_t    result_reg;
    result_t    result_next;
    logic       result_valid_reg;

    // The period register is always writable.
    assign cfg_ready = 1'b1;

    // Accept whenever the result register is empty or being emptied.
    assign item_ready = !result_valid_reg || result_ready;
    assign accept     = item_valid && item_ready;

    sws_time u_time (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .item        (item),
        .digits_next (digits_next)
    );

    // Frame for the display selected now; points lit on displays 2 and 4.
    always_comb
    begin
        unique case (select_reg)
            DISP_TENTHS:
                frame = {8'h80, seg_of(digits_next.tenths)};
            DISP_SEC_UNITS:
                frame = {8'h40, seg_of(digits_next.sec_units) & POINT_ON};
            DISP_SEC_TENS:
                frame = {8'h20, seg_of({1'b0, digits_next.sec_tens})};
            DISP_MINUTES:
                frame = {8'h10, seg_of(digits_next.minutes) & POINT_ON};
            default:
                frame = FRAME_DARK;
        endcase
    end

    // Rotate only over the displays that the leading nonzero digits need.
    assign upper_zero = (digits_next.sec_units == '0) && (digits_next.sec_tens == '0)
                        && (digits_next.minutes == '0);

    always_comb
    begin
        priority if (digits_next.minutes != '0)
        begin
            limit = DISP_MINUTES;
        end
        else if (digits_next.sec_tens != '0)
        begin
            limit = DISP_SEC_TENS;
        end
        else
        begin
            limit = DISP_SEC_UNITS;
        end

        if (upper_zero || (select_reg >= limit))
        begin
            select_next = DISP_TENTHS;
        end
        else
        begin
            select_next = select_reg + 3'd1;
        end
    end

    // Assemble the result word.
    always_comb
    begin
        result_next.frame_valid = (item.kind == KIND_REFRESH);
        result_next.frame       = (item.kind == KIND_REFRESH) ? frame : 16'h0000;
        result_next.tenths      = digits_next.tenths;
        result_next.sec_units   = digits_next.sec_units;
        result_next.sec_tens    = digits_next.sec_tens;
        result_next.minutes     = digits_next.minutes;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            select_reg       <= DISP_TENTHS;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && (item.kind == KIND_REFRESH))
            begin
                select_reg <= select_next;
            end
            if (accept)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The selection never leaves the four real displays.
    assert property (@(posedge clk) disable iff (!rst_n)
        (select_reg >= DISP_TENTHS) && (select_reg <= DISP_MINUTES))
        else $error("display selection out of range");

    // A tick result carries no frame bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.frame_valid) |-> (result.frame == 16'h0000))
        else $error("tick result carries a frame");

    // A refresh frame enables exactly one display.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.frame_valid) |-> $onehot(result.frame[15:12]))
        else $error("refresh frame without a single display enable");

    // A clear item yields all-zero digits in its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode == MODE_CLEAR)) |=>
        ((result.tenths == '0) && (result.sec_units == '0)
         && (result.sec_tens == '0) && (result.minutes == '0)))
        else $error("clear did not zero the digits");

    // Digits stay decimal.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.tenths <= 4'd9) && (result.sec_units <= 4'd9)
                          && (result.sec_tens <= 3'd5) && (result.minutes <= 4'd9)))
        else $error("digit out of decimal range");

endmodule

`default_nettype wire

>>> verif/tb_stopwatch_seven_segment_scanner.sv
// Testbench for the stopwatch scanner: directed table and random words against a predictor.
`default_nettype none

module tb_stopwatch_seven_segment_scanner;
    import sws_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 4000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned PHASE_WORDS     = 40;
    localparam int unsigned PAUSE_WORD      = 20;
    localparam int unsigned LONG_RUN_WORDS  = 260;

    // The unused mode code; the block treats it as hold.
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // One line of the stimulus table: a period write or an item word.
    typedef struct {
        bit          is_cfg;
        logic [15:0] period;
        item_t       word;
        bit          pinned;
        result_t     want;
    } plan_row_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [15:0] cfg_data     = '0;
    logic        item_valid   = 1'b0;
    item_t       item         = '0;
    logic        result_ready = 1'b0;
    logic        cfg_ready;
    logic        item_ready;
    logic        result_valid;
    result_t     result;

    // Predictor state of the stopwatch.
    logic [15:0] period_model    = PERIOD_RESET;
    logic [15:0] prescaler_model = '0;
    digits_t     digits_model    = '0;
    logic [2:0]  shown_display   = DISP_TENTHS;

    // Active-low glyphs for 0..9: bit 0 is the point, bits 7..1 are a..g.
    logic [7:0] glyph_rom [10] = '{8'h03, 8'h9F, 8'h25, 8'h0D, 8'h99,
                                   8'h49, 8'h41, 8'h1F, 8'h01, 8'h09};

    result_t     expected_q [$];
    plan_row_t   pin_q [$];
    int unsigned words_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned fault_count   = 0;
    int unsigned stuck_cycles  = 0;
    bit          hold_off_req  = 1'b0;
    bit          steady        = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    stopwatch_seven_segment_scanner i_dut (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_data              (cfg_data),
        .item_valid            (item_valid),
        .item_ready            (item_ready),
        .item                  (item),
        .result_valid          (result_valid),
        .result_ready          (result_ready),
        .result                (result)
    );

    function automatic logic [7:0] glyph(input logic [3:0] digit);
        return (digit < 4'd10) ? glyph_rom[digit] : SEG_BAD;
    endfunction

    // One tenth more, carrying through seconds and minutes; 9:59.9 wraps to zero.
    function automatic void add_tenth();
        if (digits_model.tenths < 4'd9)
        begin
            digits_model.tenths = digits_model.tenths + 4'd1;
            return;
        end
        digits_model.tenths = '0;
        if (digits_model.sec_units < 4'd9)
        begin
            digits_model.sec_units = digits_model.sec_units + 4'd1;
            return;
        end
        digits_model.sec_units = '0;
        if (digits_model.sec_tens < 3'd5)
        begin
            digits_model.sec_tens = digits_model.sec_tens + 3'd1;
            return;
        end
        digits_model.sec_tens = '0;
        digits_model.minutes = (digits_model.minutes < 4'd9) ?
                               digits_model.minutes + 4'd1 : 4'd0;
    endfunction

    // Applies one item word to the predictor state and returns the result word it causes.
    function automatic result_t predict_word(input item_t w);
        result_t    r;
        logic [2:0] last;
        r = '0;
        if (w.mode == MODE_CLEAR)
            digits_model = '0;
        if (w.kind == KIND_TICK)
        begin
            if (w.mode == MODE_RUN)
            begin
                // A zero period or a prescaler left above a lowered period completes at once.
                if ({1'b0, prescaler_model} + 17'd1 >= {1'b0, period_model})
                begin
                    prescaler_model = '0;
                    add_tenth();
                end
                else
                    prescaler_model = prescaler_model + 16'd1;
            end
        end
        else
        begin
            r.frame_valid = 1'b1;
            unique case (shown_display)
                DISP_TENTHS:    r.frame = {8'h80, glyph(digits_model.tenths)};
                DISP_SEC_UNITS: r.frame = {8'h40, glyph(digits_model.sec_units) & POINT_ON};
                DISP_SEC_TENS:  r.frame = {8'h20, glyph({1'b0, digits_model.sec_tens})};
                DISP_MINUTES:   r.frame = {8'h10, glyph(digits_model.minutes) & POINT_ON};
                default:        r.frame = FRAME_DARK;
            endcase
            // Rotate only over the displays that the leading nonzero digits need.
            if (digits_model.sec_units == 0 && digits_model.sec_tens == 0 &&
                digits_model.minutes == 0)
                shown_display = DISP_TENTHS;
            else
            begin
                if (digits_model.minutes != 0)
                    last = DISP_MINUTES;
                else if (digits_model.sec_tens != 0)
                    last = DISP_SEC_TENS;
                else
                    last = DISP_SEC_UNITS;
                shown_display = (shown_display < last) ? shown_display + 3'd1 : DISP_TENTHS;
            end
        end
        r.tenths    = digits_model.tenths;
        r.sec_units = digits_model.sec_units;
        r.sec_tens  = digits_model.sec_tens;
        r.minutes   = digits_model.minutes;
        return r;
    endfunction

    function automatic string show(input result_t r);
        return $sformatf("valid=%0b frame=%h time=%0d:%0d%0d.%0d", r.frame_valid, r.frame,
                         r.minutes, r.sec_tens, r.sec_units, r.tenths);
    endfunction

    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("ERROR at %0t: %s", $realtime, what);
    endtask

    // Mostly short gaps, a few long ones; none while a steady stretch is asked for.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic item_t random_word(input int unsigned refresh_pct,
                                          input int unsigned clear_pct,
                                          input int unsigned run_pct);
        item_t       w;
        int unsigned r;
        w.kind = ($urandom_range(0, 99) < refresh_pct) ? KIND_REFRESH : KIND_TICK;
        r = $urandom_range(0, 99);
        if (r < clear_pct)
            w.mode = MODE_CLEAR;
        else if (r < clear_pct + run_pct)
            w.mode = MODE_RUN;
        else
            w.mode = $urandom_range(0, 1) ? MODE_HOLD : MODE_SPARE;
        return w;
    endfunction

    function automatic plan_row_t period_row(input logic [15:0] v);
        plan_row_t row;
        row.is_cfg = 1'b1;
        row.period = v;
        row.word   = '0;
        row.pinned = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic plan_row_t word_row(input item_t w);
        plan_row_t row;
        row = period_row('0);
        row.is_cfg = 1'b0;
        row.word   = w;
        return row;
    endfunction

    // A word whose result is known outright: digits zero, frame as given.
    function automatic plan_row_t pinned_row(input item_t w, input logic [15:0] frame);
        plan_row_t row;
        row = word_row(w);
        row.pinned = 1'b1;
        row.want.frame_valid = w.kind;
        row.want.frame       = frame;
        return row;
    endfunction

    // Offers one item word and returns at the edge where it is taken.
    task automatic send_word(input plan_row_t row);
        int unsigned gap;
        gap = pick_gap();
        pin_q.push_back(row);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= row.word;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        words_sent++;
    endtask

    // Drops the offer and waits, edge by edge, until every result word is in.
    task automatic wait_for_results();
        item_valid <= 1'b0;
        do @(posedge clk); while (results_seen < words_sent);
    endtask

    // Period writes happen only with the block idle.
    task automatic write_period(input logic [15:0] v);
        wait_for_results();
        repeat (2) @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Scoreboard: check result words, predict on accepted item words, track period writes.
    always @(posedge clk)
    begin
        result_t   oldest;
        plan_row_t pin;
        result_t   guess;
        string     diff;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_q.size() == 0)
                    note_fault($sformatf("result word with nothing expected: %s", show(result)));
                else
                begin
                    oldest = expected_q.pop_front();
                    diff = "";
                    if (result.frame_valid !== oldest.frame_valid)
                        diff = {diff, " frame_valid"};
                    if (result.frame !== oldest.frame)
                        diff = {diff, " frame"};
                    if (result.tenths !== oldest.tenths)
                        diff = {diff, " tenths"};
                    if (result.sec_units !== oldest.sec_units)
                        diff = {diff, " sec_units"};
                    if (result.sec_tens !== oldest.sec_tens)
                        diff = {diff, " sec_tens"};
                    if (result.minutes !== oldest.minutes)
                        diff = {diff, " minutes"};
                    if (diff != "")
                        note_fault($sformatf("mismatch in%s: expected %s, got %s",
                                             diff, show(oldest), show(result)));
                end
            end
            if (item_valid && item_ready)
            begin
                pin = pin_q.pop_front();
                guess = predict_word(item);
                expected_q.push_back(pin.pinned ? pin.want : guess);
            end
            if (cfg_valid && cfg_ready)
                period_model = cfg_data;
        end
    end

    // Watchdog on cycles in which no word moves on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, and one long hold-off when the sender asks for it.
    initial
    begin
        int unsigned n;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                result_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                n = pick_gap();
                if (n == 0)
                begin
                    result_ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    result_ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
            end
        end
    end

    // Sender: directed table, random phases over several periods, then one long run.
    initial
    begin
        plan_row_t   plan [$];
        logic [15:0] period;
        int unsigned p;
        int unsigned n;

        // Reset state, holds, the unused mode code and clears read straight off.
        plan.push_back(pinned_row({KIND_REFRESH, MODE_HOLD}, 16'h8003));
        plan.push_back(pinned_row({KIND_TICK, MODE_SPARE}, 16'h0000));
        plan.push_back(pinned_row({KIND_TICK, MODE_RUN}, 16'h0000));
        plan.push_back(pinned_row({KIND_TICK, MODE_RUN}, 16'h0000));
        plan.push_back(pinned_row({KIND_REFRESH, MODE_RUN}, 16'h8003));
        // A zero period counts a tenth on every run tick.
        plan.push_back(period_row(16'h0000));
        plan.push_back(word_row({KIND_TICK, MODE_RUN}));
        plan.push_back(word_row({KIND_TICK, MODE_RUN}));
        plan.push_back(period_row(16'd1));
        plan.push_back(word_row({KIND_TICK, MODE_RUN}));
        plan.push_back(word_row({KIND_REFRESH, MODE_HOLD}));
        plan.push_back(word_row({KIND_TICK, MODE_HOLD}));
        plan.push_back(pinned_row({KIND_TICK, MODE_CLEAR}, 16'h0000));
        plan.push_back(pinned_row({KIND_REFRESH, MODE_CLEAR}, 16'h8003));
        // Largest period, then lowered below the prescaler.
        plan.push_back(period_row(16'hFFFF));
        plan.push_back(word_row({KIND_TICK, MODE_RUN}));
        plan.push_back(word_row({KIND_TICK, MODE_RUN}));
        plan.push_back(word_row({KIND_TICK, MODE_RUN}));
        plan.push_back(period_row(16'd2));
        plan.push_back(word_row({KIND_TICK, MODE_RUN}));
        plan.push_back(word_row({KIND_REFRESH, MODE_SPARE}));
        plan.push_back(word_row({KIND_TICK, MODE_RUN}));
        plan.push_back(word_row({KIND_REFRESH, MODE_RUN}));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].is_cfg)
                write_period(plan[k].period);
            else
                send_word(plan[k]);
        end

        for (p = 0; p < 8; p++)
        begin
            unique case (p)
                0:       period = 16'd1;
                1:       period = 16'd2;
                2:       period = 16'd0;
                3:       period = 16'd3;
                4:       period = 16'hFFFF;
                5:       period = 16'($urandom_range(1, 6));
                6:       period = 16'd1;
                default: period = 16'($urandom_range(0, 65535));
            endcase
            write_period(period);
            steady = (p == 2);
            // Fill the block against a long result stall.
            if (p == 4)
            begin
                steady = 1'b1;
                hold_off_req = 1'b1;
            end
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (p == 1 && n == PAUSE_WORD)
                    wait_for_results();
                send_word(word_row(random_word(35, 4, 60)));
            end
            steady = 1'b0;
        end

        // Long run at one tick per tenth: carries into the seconds tens display.
        write_period(16'd1);
        for (n = 0; n < LONG_RUN_WORDS; n++)
            send_word(word_row(random_word(8, 0, 96)));

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
            note_fault($sformatf("%0d result words never arrived", expected_q.size()));
        if (fault_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
